FILE: design/was_pkg.sv
package was_pkg;

    // fixed field widths
    localparam int WORD_BITS   = 16;
    localparam int ERR_BIT     = 14;
    localparam int ZONE_BITS   = 8;
    localparam int WEIGHT_BITS = 17;
    localparam int W_FRAC      = 16;

    // angle format
    localparam int ANGLE_BITS = 14;
    localparam int FRAC_BITS  = 16;
    localparam int EST_BITS   = ANGLE_BITS + FRAC_BITS;

    // signed difference width and product width
    localparam int D_BITS    = EST_BITS + 2;
    localparam int PROD_BITS = D_BITS + WEIGHT_BITS + 1;

    // config port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = WEIGHT_BITS;

    typedef logic [WORD_BITS-1:0]  t_word;
    typedef logic [ANGLE_BITS-1:0] t_angle;
    typedef logic [EST_BITS-1:0]   t_est;
    typedef logic [WEIGHT_BITS-1:0] t_weight;
    typedef logic [ZONE_BITS-1:0]  t_zone;

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FILTER_MODE      = 2'd0,
        REG_SMOOTHING_FACTOR = 2'd1,
        REG_NULL_ZONE        = 2'd2
    } t_reg_idx;

    // filter modes
    typedef enum logic {
        MODE_SMOOTH   = 1'b0,
        MODE_DEADBAND = 1'b1
    } t_mode;

    localparam t_weight WEIGHT_ONE = {1'b1, {W_FRAC{1'b0}}};
    localparam t_weight SMOOTH_RESET = {3'b001, {(W_FRAC-2){1'b0}}};

    // one full turn and half a turn in the signed difference domain
    localparam logic signed [D_BITS-1:0] D_FULL = {2'b01, {EST_BITS{1'b0}}};
    localparam logic signed [D_BITS-1:0] D_HALF = {3'b001, {(EST_BITS-1){1'b0}}};

    // rounding offsets
    localparam logic [PROD_BITS-1:0] PROD_ROUND =
        PROD_BITS'({1'b1, {(W_FRAC-1){1'b0}}});
    localparam t_est EST_ROUND = EST_BITS'({1'b1, {(FRAC_BITS-1){1'b0}}});

endpackage

FILE: design/was_in_if.sv
interface was_in_if;
    logic             valid;
    logic             ready;
    was_pkg::t_word   response_word;

    modport source (output valid, output response_word, input ready);
    modport sink   (input valid, input response_word, output ready);
endinterface

FILE: design/was_out_if.sv
interface was_out_if;
    logic             valid;
    logic             ready;
    was_pkg::t_angle  filtered_angle;
    logic             error_flag;

    modport source (output valid, output filtered_angle, output error_flag, input ready);
    modport sink   (input valid, input filtered_angle, input error_flag, output ready);
endinterface

FILE: design/wrapping_angle_smoother.sv
// Wrapping angle smoother: circular exponential moving average (or dead-band
// hold) over angle sensor response words.
// i_in carries one 16-bit response word per word: bit 14 is the sensor error
// flag, the low angle bits are the sample. o_out returns one word per input
// word: the filtered angle and a copy of the error flag.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data):
// index 0 filter mode, 1 smoothing factor (Q1.16), 2 null zone in ticks.
// Write it only while no word is in flight.
// The input register feeds the update logic straight into the output
// register. One word per cycle is taken while the receiver does not stall;
// the estimate update (difference, one 32x18 multiply, round and wrap) is
// combinational and closes its loop through the estimate register alone.
// Reset clears the estimate to zero, loads the register defaults (smoothing
// mode, factor 0.25, null zone 0) and empties both stages.
// When the receiver stalls, the output register holds its word, the input
// register still takes one more word, and i_in.ready then drops until the
// output register drains.
module wrapping_angle_smoother (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    was_in_if.sink                             i_in,
    was_out_if.source                          o_out,
    input  logic                               i_cfg_we,
    input  logic [was_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [was_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int EB = was_pkg::EST_BITS;
    localparam int DB = was_pkg::D_BITS;
    localparam int PB = was_pkg::PROD_BITS;
    localparam int AB = was_pkg::ANGLE_BITS;
    localparam int FB = was_pkg::FRAC_BITS;

    // configuration registers
    was_pkg::t_mode   r_mode;
    was_pkg::t_weight r_factor;
    was_pkg::t_zone   r_zone;

    // pipeline registers
    logic             r_s1_valid;
    was_pkg::t_word   r_word;
    logic             r_out_valid;
    was_pkg::t_angle  r_angle;
    logic             r_err;
    was_pkg::t_est    r_est;

    // next values
    was_pkg::t_est    n_est;
    was_pkg::t_angle  n_angle;

    // datapath
    logic                    advance;
    was_pkg::t_angle         sample;
    was_pkg::t_est           s_fixed;
    was_pkg::t_weight        weight;
    logic signed [DB-1:0]    diff;
    logic signed [DB-1:0]    diff_wrap;
    logic signed [DB-1:0]    diff_abs;
    logic signed [DB-1:0]    zone_fixed;
    logic signed [PB-1:0]    prod;
    logic [PB-1:0]           prod_rnd;
    was_pkg::t_est           est_smooth;
    was_pkg::t_est           est_rnd;

    // handshake
    assign advance     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || advance;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= was_pkg::MODE_SMOOTH;
            r_factor <= was_pkg::SMOOTH_RESET;
            r_zone   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                was_pkg::REG_FILTER_MODE:      r_mode   <= was_pkg::t_mode'(i_cfg_data[0]);
                was_pkg::REG_SMOOTHING_FACTOR: r_factor <= i_cfg_data;
                was_pkg::REG_NULL_ZONE:        r_zone   <= i_cfg_data[was_pkg::ZONE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // update logic
    always_comb begin
        sample     = r_word[AB-1:0];
        s_fixed    = {sample, {FB{1'b0}}};
        weight     = (r_factor > was_pkg::WEIGHT_ONE) ? was_pkg::WEIGHT_ONE : r_factor;
        diff       = $signed({2'b00, s_fixed}) - $signed({2'b00, r_est});

        // unwrap across the turn boundary
        if (diff < -was_pkg::D_HALF) begin
            diff_wrap = diff + was_pkg::D_FULL;
        end else if (diff > was_pkg::D_HALF) begin
            diff_wrap = diff - was_pkg::D_FULL;
        end else begin
            diff_wrap = diff;
        end

        // weighted step toward the sample, rounded, wrapped into one turn
        prod       = PB'(diff_wrap) * $signed({1'b0, weight});
        prod_rnd   = $unsigned(prod) + was_pkg::PROD_ROUND;
        est_smooth = r_est + prod_rnd[was_pkg::W_FRAC +: EB];
        est_rnd    = est_smooth + was_pkg::EST_ROUND;

        // dead-band compare without wrap
        diff_abs   = (diff < 0) ? -diff : diff;
        zone_fixed = DB'({r_zone, {FB{1'b0}}});

        if (r_mode == was_pkg::MODE_DEADBAND) begin
            if (diff_abs > zone_fixed) begin
                n_est   = s_fixed;
                n_angle = sample;
            end else begin
                n_est   = r_est;
                n_angle = r_est[EB-1:FB];
            end
        end else begin
            n_est   = est_smooth;
            n_angle = est_rnd[EB-1:FB];
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_word <= i_in.response_word;
        end
    end

    // estimate and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_est       <= n_est;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_angle <= n_angle;
            r_err   <= r_word[was_pkg::ERR_BIT];
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.filtered_angle = r_angle;
    assign o_out.error_flag     = r_err;

endmodule
